// ----- src/grid_ray_march_range_macros.svh -----
// ----------------------------------------------------------------------------
// Grid ray march range: assertion macros
// Shared assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_MARCH_RANGE_MACROS_SVH
`define GRID_RAY_MARCH_RANGE_MACROS_SVH

// Same-cycle implication
`define GRMR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define GRMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/grmr_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid ray march range: package
// Shared constants, codes and state type of the ray marcher.
// ----------------------------------------------------------------------------
package grmr_pkg;

  // Parameter defaults
  localparam int GRID_DIM_DEF        = 256;
  localparam int MAX_STEPS_LIMIT_DEF = 1024;
  localparam int ANGLE_BITS_DEF      = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;

  // Quarter-wave polynomial coefficients, Q16
  localparam logic [MUL_W-1:0] POLY_A = 17'd102944;
  localparam logic [MUL_W-1:0] POLY_B = 17'd42048;
  localparam logic [MUL_W-1:0] POLY_C = 17'd4640;

  // Largest Q1.15 magnitude
  localparam logic [14:0] Q15_MAX = 15'h7fff;

  // Full quarter-wave phase (z = 1.0 in Q16)
  localparam logic [MUL_W-1:0] Z_ONE = 17'h10000;

  // Cell kinds and actions
  localparam logic [1:0] KIND_FREE = 2'd0;
  localparam logic       ACT_WRITE = 1'b0;

  // Result status codes
  typedef enum logic [2:0] {
    STS_HIT        = 3'd0,
    STS_MAX_RANGE  = 3'd1,
    STS_LEFT_MAP   = 3'd2,
    STS_BAD_ANGLE  = 3'd3,
    STS_WRITE_DONE = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_POSE_X     = 3'd0,
    CFG_POSE_Y     = 3'd1,
    CFG_POSE_THETA = 3'd2,
    CFG_FOV        = 3'd3,
    CFG_MAX_STEPS  = 3'd4,
    CFG_MAP_WIDTH  = 3'd5,
    CFG_MAP_HEIGHT = 3'd6
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ZSET,
    S_MUL_ZZ,
    S_MUL_Z2C,
    S_SUB_B,
    S_MUL_Z2T,
    S_SUB_A,
    S_MUL_ZT,
    S_SCALE,
    S_INIT,
    S_MARCH
  } state_t;

endpackage

// ----- src/grmr_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module grmr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/grmr_mul.sv -----
// ----------------------------------------------------------------------------
// Grid ray march range: shared multiplier
// Unsigned multiplier with a registered product, reused for every term of
// the sine polynomial.
// ----------------------------------------------------------------------------
module grmr_mul (
  input  logic                         clk,
  input  logic [grmr_pkg::MUL_W-1:0]  a,
  input  logic [grmr_pkg::MUL_W-1:0]  b,
  output logic [grmr_pkg::PROD_W-1:0] p
);

  logic [grmr_pkg::PROD_W-1:0] p_r;

  // Product register
  always_ff @(posedge clk) begin
    p_r <= grmr_pkg::PROD_W'(a) * grmr_pkg::PROD_W'(b);
  end

  assign p = p_r;

endmodule

// ----- src/grid_ray_march_range.sv -----
// ----------------------------------------------------------------------------
// Grid ray march range
// Occupancy grid with a half-cell ray marcher; sine and cosine come from a
// quarter-wave polynomial evaluated on one shared multiplier.
// ----------------------------------------------------------------------------
// Channel   Ports                               Transfer
// input     start, busy, in_*                   start high while busy low
// result    out_valid, out_*                    out_valid high, one cycle
// config    cfg_we, cfg_index, cfg_wdata        cfg_we high
//
// A write item or a rejected angle gives its result in the cycle after the
// transfer and the block is ready again at once. A cast computes sine and
// then cosine on the shared multiplier, sets up the first position, takes
// one half-cell step per cycle (one grid read per step) and then checks the
// last read. After reset the grid's GRID_DIM*GRID_DIM cells (65536 by
// default) are cleared one per cycle, busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "grid_ray_march_range_macros.svh"

module grid_ray_march_range #(
  parameter int GRID_DIM        = grmr_pkg::GRID_DIM_DEF,
  parameter int MAX_STEPS_LIMIT = grmr_pkg::MAX_STEPS_LIMIT_DEF,
  parameter int ANGLE_BITS      = grmr_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [7:0]         in_cell_x,
  input  logic [7:0]         in_cell_y,
  input  logic [1:0]         in_cell_kind,
  input  logic signed [15:0] in_rel_angle,
  // Result channel
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [10:0]        out_range_steps,
  output logic [1:0]         out_hit_kind,
  output logic [7:0]         out_hit_x,
  output logic [7:0]         out_hit_y,
  // Configuration port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  localparam int DEPTH  = GRID_DIM * GRID_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CELL_W = $clog2(GRID_DIM);
  localparam int DIM_W  = $clog2(GRID_DIM + 1);
  localparam int STEP_W = $clog2(MAX_STEPS_LIMIT + 1);
  localparam int K_W    = $clog2(MAX_STEPS_LIMIT + 2);
  localparam int POS_W  = ((K_W > 10) ? K_W : 10) + 17;
  localparam int CX_W   = POS_W - 17;
  localparam int IDX_W  = ANGLE_BITS;
  localparam int MW     = grmr_pkg::MUL_W;

  // Configuration registers
  logic [15:0] pose_x_r, pose_y_r, pose_theta_r, fov_r;
  logic [10:0] max_steps_r;
  logic [8:0]  map_width_r, map_height_r;

  // Sequencer state
  grmr_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              pend_r, pend_nxt;

  // Angle and polynomial datapath
  logic [15:0]       g_r, g_nxt;
  logic              wave_cos_r, wave_cos_nxt;
  logic              neg_r, neg_nxt;
  logic [MW-1:0]     z_r, z_nxt;
  logic [MW-1:0]     z2_r, z2_nxt;
  logic [MW-1:0]     t_r, t_nxt;
  logic signed [15:0] sin_r, sin_nxt;
  logic signed [15:0] cos_r, cos_nxt;

  // March datapath
  logic signed [POS_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [K_W-1:0]          k_r, k_nxt, kp_r, kp_nxt;
  logic [CELL_W-1:0]       cxp_r, cxp_nxt, cyp_r, cyp_nxt;

  // Result registers
  logic                 out_valid_r, out_valid_nxt;
  grmr_pkg::status_t    out_status_r, out_status_nxt;
  logic [10:0]          out_range_r, out_range_nxt;
  logic [1:0]           out_kind_r, out_kind_nxt;
  logic [7:0]           out_hx_r, out_hx_nxt, out_hy_r, out_hy_nxt;

  // Combinational helpers
  logic                    accept;
  logic [STEP_W-1:0]       lim;
  logic [DIM_W-1:0]        w_eff, h_eff;
  logic signed [17:0]      rel2, fov18;
  logic                    bad_angle;
  logic [IDX_W-1:0]        idx;
  logic [1:0]              quad;
  logic [IDX_W-3:0]        frac;
  logic [MW-1:0]           z_raw;
  logic [MW-1:0]           p_hi;
  logic [17:0]             rnd;
  logic [16:0]             half;
  logic [14:0]             mag;
  logic signed [15:0]      trig_val;
  logic signed [POS_W-1:0] base_x, base_y;
  logic [CX_W-1:0]         cx_full, cy_full;
  logic [CELL_W-1:0]       cx_i, cy_i;
  logic                    off_map;
  logic                    wr_in_grid;
  logic [MW-1:0]           mul_a, mul_b;
  logic [grmr_pkg::PROD_W-1:0] mul_p;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [1:0]              ram_wdata, ram_rdata;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pose_x_r     <= '0;
      pose_y_r     <= '0;
      pose_theta_r <= '0;
      fov_r        <= '0;
      max_steps_r  <= '0;
      map_width_r  <= 9'd256;
      map_height_r <= 9'd256;
    end else if (cfg_we) begin
      case (grmr_pkg::cfg_idx_t'(cfg_index))
        grmr_pkg::CFG_POSE_X:     pose_x_r     <= cfg_wdata;
        grmr_pkg::CFG_POSE_Y:     pose_y_r     <= cfg_wdata;
        grmr_pkg::CFG_POSE_THETA: pose_theta_r <= cfg_wdata;
        grmr_pkg::CFG_FOV:        fov_r        <= cfg_wdata;
        grmr_pkg::CFG_MAX_STEPS:  max_steps_r  <= cfg_wdata[10:0];
        grmr_pkg::CFG_MAP_WIDTH:  map_width_r  <= cfg_wdata[8:0];
        grmr_pkg::CFG_MAP_HEIGHT: map_height_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // Effective limits
  assign lim   = (32'(max_steps_r) > 32'(MAX_STEPS_LIMIT)) ?
                 STEP_W'(MAX_STEPS_LIMIT) : STEP_W'(max_steps_r);
  assign w_eff = (32'(map_width_r) > 32'(GRID_DIM)) ? DIM_W'(GRID_DIM) : DIM_W'(map_width_r);
  assign h_eff = (32'(map_height_r) > 32'(GRID_DIM)) ? DIM_W'(GRID_DIM) : DIM_W'(map_height_r);

  // Field of view check: 2*rel against +/- fov
  assign rel2      = {in_rel_angle[15], in_rel_angle, 1'b0};
  assign fov18     = $signed({2'b00, fov_r});
  assign bad_angle = (rel2 > fov18) || (rel2 < -fov18);

  assign accept = start && (state_r == grmr_pkg::S_IDLE);
  assign busy   = (state_r != grmr_pkg::S_IDLE);

  // Table index and quarter-wave phase
  assign idx   = IDX_W'(({20'b0, g_r} << ANGLE_BITS) >> 16);
  assign quad  = idx[IDX_W-1 -: 2] + {1'b0, wave_cos_r};
  assign frac  = idx[IDX_W-3:0];
  assign z_raw = MW'(({frac, 16'b0}) >> (ANGLE_BITS - 2));

  // Product high part and Q1.15 rounding
  assign p_hi     = mul_p[16 +: MW];
  assign rnd      = {1'b0, p_hi} + 18'd1;
  assign half     = rnd[17:1];
  assign mag      = (half > 17'(grmr_pkg::Q15_MAX)) ? grmr_pkg::Q15_MAX : half[14:0];
  assign trig_val = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  // Current march cell
  assign base_x  = POS_W'($signed({1'b0, pose_x_r, 8'b0}));
  assign base_y  = POS_W'($signed({1'b0, pose_y_r, 8'b0}));
  assign cx_full = px_r[POS_W-2:16];
  assign cy_full = py_r[POS_W-2:16];
  assign cx_i    = cx_full[CELL_W-1:0];
  assign cy_i    = cy_full[CELL_W-1:0];
  assign off_map = px_r[POS_W-1] || py_r[POS_W-1] ||
                   (32'(cx_full) >= 32'(w_eff)) || (32'(cy_full) >= 32'(h_eff));
  assign ram_raddr = ADDR_W'(cy_i) * ADDR_W'(GRID_DIM) + ADDR_W'(cx_i);

  assign wr_in_grid = (32'(in_cell_x) < 32'(GRID_DIM)) && (32'(in_cell_y) < 32'(GRID_DIM));

  // Sequencer: next state, datapath and result
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    pend_nxt       = 1'b0;
    g_nxt          = g_r;
    wave_cos_nxt   = wave_cos_r;
    neg_nxt        = neg_r;
    z_nxt          = z_r;
    z2_nxt         = z2_r;
    t_nxt          = t_r;
    sin_nxt        = sin_r;
    cos_nxt        = cos_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    k_nxt          = k_r;
    kp_nxt         = kp_r;
    cxp_nxt        = cxp_r;
    cyp_nxt        = cyp_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_range_nxt  = out_range_r;
    out_kind_nxt   = out_kind_r;
    out_hx_nxt     = out_hx_r;
    out_hy_nxt     = out_hy_r;
    mul_a          = '0;
    mul_b          = '0;
    ram_we         = 1'b0;
    ram_waddr      = ADDR_W'(in_cell_y) * ADDR_W'(GRID_DIM) + ADDR_W'(in_cell_x);
    ram_wdata      = in_cell_kind;

    case (state_r)
      // Reset sweep: one cell per cycle
      grmr_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = grmr_pkg::KIND_FREE;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = grmr_pkg::S_IDLE;
        end
      end

      grmr_pkg::S_IDLE: begin
        if (accept) begin
          if (in_action == grmr_pkg::ACT_WRITE) begin
            ram_we         = wr_in_grid;
            out_valid_nxt  = 1'b1;
            out_status_nxt = grmr_pkg::STS_WRITE_DONE;
            out_range_nxt  = '0;
            out_kind_nxt   = '0;
            out_hx_nxt     = '0;
            out_hy_nxt     = '0;
          end else if (bad_angle) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = grmr_pkg::STS_BAD_ANGLE;
            out_range_nxt  = '0;
            out_kind_nxt   = '0;
            out_hx_nxt     = '0;
            out_hy_nxt     = '0;
          end else begin
            g_nxt        = pose_theta_r + in_rel_angle;
            wave_cos_nxt = 1'b0;
            state_nxt    = grmr_pkg::S_ZSET;
          end
        end
      end

      // Phase within quadrant; odd quadrants mirror
      grmr_pkg::S_ZSET: begin
        z_nxt     = quad[0] ? (grmr_pkg::Z_ONE - z_raw) : z_raw;
        neg_nxt   = quad[1];
        state_nxt = grmr_pkg::S_MUL_ZZ;
      end

      grmr_pkg::S_MUL_ZZ: begin
        mul_a     = z_r;
        mul_b     = z_r;
        state_nxt = grmr_pkg::S_MUL_Z2C;
      end

      grmr_pkg::S_MUL_Z2C: begin
        z2_nxt    = p_hi;
        mul_a     = p_hi;
        mul_b     = grmr_pkg::POLY_C;
        state_nxt = grmr_pkg::S_SUB_B;
      end

      grmr_pkg::S_SUB_B: begin
        t_nxt     = grmr_pkg::POLY_B - p_hi;
        state_nxt = grmr_pkg::S_MUL_Z2T;
      end

      grmr_pkg::S_MUL_Z2T: begin
        mul_a     = z2_r;
        mul_b     = t_r;
        state_nxt = grmr_pkg::S_SUB_A;
      end

      grmr_pkg::S_SUB_A: begin
        t_nxt     = grmr_pkg::POLY_A - p_hi;
        state_nxt = grmr_pkg::S_MUL_ZT;
      end

      grmr_pkg::S_MUL_ZT: begin
        mul_a     = z_r;
        mul_b     = t_r;
        state_nxt = grmr_pkg::S_SCALE;
      end

      // Round to Q1.15, then sine pass is followed by cosine pass
      grmr_pkg::S_SCALE: begin
        if (wave_cos_r) begin
          cos_nxt   = trig_val;
          state_nxt = grmr_pkg::S_INIT;
        end else begin
          sin_nxt      = trig_val;
          wave_cos_nxt = 1'b1;
          state_nxt    = grmr_pkg::S_ZSET;
        end
      end

      // Position of the first step
      grmr_pkg::S_INIT: begin
        px_nxt    = base_x + POS_W'(cos_r);
        py_nxt    = base_y + POS_W'(sin_r);
        k_nxt     = K_W'(1);
        state_nxt = grmr_pkg::S_MARCH;
      end

      // One step per cycle; the read of the previous step is checked first
      grmr_pkg::S_MARCH: begin
        if (pend_r && (ram_rdata != grmr_pkg::KIND_FREE)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = grmr_pkg::STS_HIT;
          out_range_nxt  = 11'(kp_r);
          out_kind_nxt   = ram_rdata;
          out_hx_nxt     = 8'(cxp_r);
          out_hy_nxt     = 8'(cyp_r);
          state_nxt      = grmr_pkg::S_IDLE;
        end else if (k_r > K_W'(lim)) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = grmr_pkg::STS_MAX_RANGE;
          out_range_nxt  = 11'(lim);
          out_kind_nxt   = '0;
          out_hx_nxt     = '0;
          out_hy_nxt     = '0;
          state_nxt      = grmr_pkg::S_IDLE;
        end else if (off_map) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = grmr_pkg::STS_LEFT_MAP;
          out_range_nxt  = 11'(lim);
          out_kind_nxt   = '0;
          out_hx_nxt     = '0;
          out_hy_nxt     = '0;
          state_nxt      = grmr_pkg::S_IDLE;
        end else begin
          pend_nxt = 1'b1;
          kp_nxt   = k_r;
          cxp_nxt  = cx_i;
          cyp_nxt  = cy_i;
          px_nxt   = px_r + POS_W'(cos_r);
          py_nxt   = py_r + POS_W'(sin_r);
          k_nxt    = k_r + 1'b1;
        end
      end

      default: begin
        state_nxt = grmr_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grmr_pkg::S_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk) begin
    g_r          <= g_nxt;
    wave_cos_r   <= wave_cos_nxt;
    neg_r        <= neg_nxt;
    z_r          <= z_nxt;
    z2_r         <= z2_nxt;
    t_r          <= t_nxt;
    sin_r        <= sin_nxt;
    cos_r        <= cos_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    k_r          <= k_nxt;
    kp_r         <= kp_nxt;
    cxp_r        <= cxp_nxt;
    cyp_r        <= cyp_nxt;
    out_status_r <= out_status_nxt;
    out_range_r  <= out_range_nxt;
    out_kind_r   <= out_kind_nxt;
    out_hx_r     <= out_hx_nxt;
    out_hy_r     <= out_hy_nxt;
  end

  // Shared multiplier
  grmr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Occupancy grid
  grmr_ram #(
    .WIDTH (2),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_range_steps = out_range_r;
  assign out_hit_kind    = out_kind_r;
  assign out_hit_x       = out_hx_r;
  assign out_hit_y       = out_hy_r;

  // Checks
  `GRMR_ASSERT_NOW(a_grid_write_idle, ram_we, (state_r == grmr_pkg::S_IDLE) || (state_r == grmr_pkg::S_CLEAR), "grid written outside idle or clear")
  `GRMR_ASSERT_NOW(a_pend_in_march, pend_r, state_r == grmr_pkg::S_MARCH, "pending read outside march")
  `GRMR_ASSERT_NOW(a_hit_kind, out_valid_r && (out_status_r == grmr_pkg::STS_HIT), out_kind_r != grmr_pkg::KIND_FREE, "hit reported on a free cell")
  `GRMR_ASSERT_NEXT(a_write_result, accept && (in_action == grmr_pkg::ACT_WRITE), out_valid_r && (out_status_r == grmr_pkg::STS_WRITE_DONE), "write item without result")

endmodule
